// File: hdl/rmsb_pkg.sv
// ============================================================================
// rmsb_pkg
// Shared widths, defaults and interface types for the RMS block.
// ============================================================================
package rmsb_pkg;

   // Input sample port width and default parameter values.
   localparam int SAMPLE_W            = 16;
   localparam int DEF_SAMPLE_BITS     = 16;
   localparam int DEF_MAX_SAMPLES     = 65536;

   // Accumulator, count and result widths.
   localparam int SUM_W               = 47;
   localparam int CNT_W               = 17;
   localparam int RMS_W               = 24;

   // Fixed-point scale: the mean square is shifted up by this many bits,
   // which gives eight fraction bits after the square root.
   localparam int FRAC_SHIFT          = 16;

   // Divider: dividend/quotient shift register and one step per bit.
   localparam int DQ_W                = SUM_W + FRAC_SHIFT;
   localparam int DIV_STEPS           = DQ_W;

   // Square root: the quotient is at most 2^46, so 48 input bits and two bits
   // per step are enough for a 24-bit root.
   localparam int SQRT_IN_W           = 2 * RMS_W;
   localparam int SQRT_STEPS          = RMS_W;
   localparam int REM_W               = RMS_W + 1;

   // Shared subtractor width covers both the divide and the root trial.
   localparam int ALU_W               = REM_W + 2;
   localparam int STEP_W              = $clog2(DIV_STEPS);

   // Request from the top level to the arithmetic unit.
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } rmsb_job_type;

   // Status from the arithmetic unit.
   typedef struct packed {
      logic             done;
      logic [RMS_W-1:0] root;
   } rmsb_res_type;

endpackage

// File: hdl/rmsb_divsqrt.sv
// ============================================================================
// rmsb_divsqrt
// Sequenced divide and square root over one shared subtractor.
// Computes floor(sqrt(floor(sum * 2^16 / count))): a restoring divide, one
// quotient bit per cycle, then a restoring root, one root bit per cycle.
// ============================================================================
module rmsb_divsqrt
   import rmsb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rmsb_job_type job,
   output rmsb_res_type res
);

   typedef enum logic [1:0] {
      U_IDLE,
      U_DIV,
      U_SQRT,
      U_DONE
   } unit_state_type;

   unit_state_type      state_ff, state_in;
   logic [DQ_W-1:0]     dq_ff, dq_in;
   logic [CNT_W-1:0]    r_ff, r_in;
   logic [CNT_W-1:0]    c_ff, c_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [RMS_W-1:0]    root_ff, root_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [ALU_W-1:0]    alu_a, alu_b;
   logic [ALU_W:0]      alu_diff;
   logic                alu_ge;
   logic [CNT_W:0]      div_part;
   logic [ALU_W-1:0]    sqrt_part;

   // Partial remainders for the two kinds of step.
   assign div_part  = {r_ff, dq_ff[DQ_W-1]};
   assign sqrt_part = {rem_ff, dq_ff[SQRT_IN_W-1 -: 2]};

   // Shared subtractor; the top bit of the difference is the borrow.
   always_comb begin
      if (state_ff == U_SQRT) begin
         alu_a = sqrt_part;
         alu_b = ALU_W'({root_ff, 2'b01});
      end else begin
         alu_a = ALU_W'(div_part);
         alu_b = ALU_W'(c_ff);
      end
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge   = !alu_diff[ALU_W];
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      dq_in    = dq_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      if (job.start) begin
         state_in = U_DIV;
         dq_in    = {job.sum, FRAC_SHIFT'(0)};
         r_in     = '0;
         c_in     = job.count;
         step_in  = '0;
      end else begin
         unique case (state_ff)
            U_DIV: begin
               r_in  = alu_ge ? alu_diff[CNT_W-1:0] : div_part[CNT_W-1:0];
               dq_in = {dq_ff[DQ_W-2:0], alu_ge};
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_in = U_SQRT;
                  step_in  = '0;
                  rem_in   = '0;
                  root_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            U_SQRT: begin
               rem_in  = alu_ge ? alu_diff[REM_W-1:0] : sqrt_part[REM_W-1:0];
               root_in = {root_ff[RMS_W-2:0], alu_ge};
               dq_in   = {dq_ff[DQ_W-3:0], 2'b00};
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  state_in = U_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            U_IDLE, U_DONE: begin
               state_in = state_ff;
            end
            default: begin
               state_in = U_IDLE;
            end
         endcase
      end
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      dq_ff   <= dq_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign res.done = (state_ff == U_DONE);
   assign res.root = root_ff;

endmodule

// File: hdl/rms_of_sample_block.sv
// ============================================================================
// rms_of_sample_block
// RMS of a block of signed samples, 8 fraction bits, floored.
//
//   Channel  Direction  Payload                                   Beat when
//   req_     in         sample, last                              req_valid & req_ready
//   rsp_     out        rms_value, sample_count, overflow         rsp_valid & rsp_ready
//
// A sample without last is squared and accumulated at one beat per cycle.
// A last beat leads to the result through the final add, 63 divide steps
// and 24 root steps on the shared subtractor, and the load of the result
// register. req_ready is low meanwhile.
// If the previous result is still waiting, the new one waits in the unit.
// Reset is synchronous and clears the sum, the count and the drop flag.
// ============================================================================
module rms_of_sample_block
   import rmsb_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RMS_W-1:0]    rsp_rms_value,
   output logic [CNT_W-1:0]    rsp_sample_count,
   output logic                rsp_overflow
);

   localparam int SQ_W = 2 * SAMPLE_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_CALC
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]       rms_ff, rms_in;
   logic [CNT_W-1:0]       cnt_out_ff, cnt_out_in;
   logic                   ovf_ff, ovf_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   drop_ff, drop_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic                   sq_valid_ff, sq_valid_in;

   logic [SAMPLE_BITS-1:0] smp;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   beat_in;
   logic                   full;
   logic                   load_rsp;
   rmsb_job_type           job;
   rmsb_res_type           res;

   // Magnitude of the sample read as a SAMPLE_BITS-wide signed value.
   assign smp   = req_sample[SAMPLE_BITS-1:0];
   assign mag   = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
   assign sq_in = SQ_W'(mag) * SQ_W'(mag);

   assign req_ready = (state_ff == S_IDLE);
   assign beat_in   = req_valid && req_ready;
   assign full      = (count_ff >= CNT_W'(MAX_SAMPLES));
   assign load_rsp  = (state_ff == S_CALC) && res.done && (!rsp_valid_ff || rsp_ready);

   // Hand the final sum and count to the arithmetic unit.
   assign job.start = (state_ff == S_ADD);
   assign job.sum   = sum_in;
   assign job.count = count_ff;

   rmsb_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .job   (job),
      .res   (res)
   );

   // Next values for the accumulator, the sequencer and the result register.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rms_in       = rms_ff;
      cnt_out_in   = cnt_out_ff;
      ovf_in       = ovf_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      sq_valid_in  = 1'b0;
      sum_in       = sq_valid_ff ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;

      // Count the beat or drop it when the block is full.
      if (beat_in) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in    = count_ff + 1'b1;
            sq_valid_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (beat_in && req_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (load_rsp) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rms_in       = (count_ff == '0) ? '0 : res.root;
               cnt_out_in   = count_ff;
               ovf_in       = drop_ff;
               sum_in       = '0;
               count_in     = '0;
               drop_in      = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, accumulator and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         sq_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         sq_valid_ff  <= sq_valid_in;
      end
      sq_ff      <= sq_in;
      rms_ff     <= rms_in;
      cnt_out_ff <= cnt_out_in;
      ovf_ff     <= ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rms_value    = rms_ff;
   assign rsp_sample_count = cnt_out_ff;
   assign rsp_overflow     = ovf_ff;

   // The sample count never passes the block size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count exceeds the block size");

   // A new result appears only when the computation finishes.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_CALC))
      else $error("result raised outside the calculation phase");

   // A last beat always starts the final add.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      beat_in && req_last |=> state_ff == S_ADD)
      else $error("last beat did not start the calculation");

   // A pending square always comes from an accepted beat.
   a_sq_source: assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff |-> $past(beat_in))
      else $error("square pending without an accepted beat");

endmodule
